@@ rtl/rrsd_pkg.sv @@
// shared types and constants for the row run straight segment detector
// no dependencies; imported by every rtl module of the block
package rrsd_pkg;

    // fixed field widths of the stream payloads
    localparam int CFG_W       = 16;
    localparam int DEPTH_IN_W  = 16;
    localparam int ROW_OUT_W   = 11;
    localparam int COL_OUT_W   = 11;
    localparam int LEN_OUT_W   = 12;
    localparam int LABEL_W     = 16;

    // bus widths, tdata padded to whole bytes
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAD_W     = M_TDATA_W - ROW_OUT_W - COL_OUT_W - LEN_OUT_W - LABEL_W;

    // bit positions in s_tuser
    localparam int TUSER_EDGE_BIT   = 0;
    localparam int TUSER_FRAME_BIT  = 1;

    localparam logic [LABEL_W-1:0] LABEL_MAX = {LABEL_W{1'b1}};

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_DEPTH_BITS = 16;

    // one pixel as held in the input register
    typedef struct packed {
        logic                  edge_bit;
        logic [DEPTH_IN_W-1:0] depth;
        logic                  row_end;
        logic                  frame_start;
    } pixel_t;

    // one straight segment report
    typedef struct packed {
        logic [LABEL_W-1:0]   segment_label;
        logic [LEN_OUT_W-1:0] segment_length;
        logic [COL_OUT_W-1:0] segment_start_col;
        logic [ROW_OUT_W-1:0] segment_row;
    } result_t;

    // stage handshake between input register, run core and result register
    typedef struct packed {
        logic vld;
        logic adv;
    } stage_ctl_t;

endpackage

@@ rtl/row_run_straight_segment_detector.sv @@
// top level of the row run straight segment detector
// depends on rrsd_pkg, rrsd_in_stage, rrsd_run_core, rrsd_out_stage

// Takes one raster pixel per clock (edge bit, depth, row end, frame start) and
// reports each straight horizontal run as one master-side transfer carrying
// row, start column, length and label. Throughput is one pixel per cycle
// while the result register is free or taken; pixels pass the input register,
// run update and result register. slope_threshold is written through
// cfg_wr_en/cfg_wr_data only while the block is idle, a user rule the block
// does not enforce. No clearing pass after reset: the block is ready at once.
module row_run_straight_segment_detector #(
    parameter int MAX_WIDTH  = rrsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rrsd_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = rrsd_pkg::DEF_DEPTH_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slope_threshold
    input  logic                           cfg_wr_en,
    input  logic [rrsd_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrsd_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] depth
    input  logic                           s_tlast,   // row_end
    input  logic [rrsd_pkg::S_TUSER_W-1:0] s_tuser,   // [0] edge_bit, [1] frame_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] segment_row, [21:11] segment_start_col, [33:22] segment_length,
    // [49:34] segment_label, [55:50] zero
    output logic [rrsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrsd_pkg::*;

    stage_ctl_t ctl;
    pixel_t     pix;
    result_t    res;
    logic       res_vld;
    logic       adv;
    logic       pix_vld;

    // stage handshake gathered for the core
    assign ctl = '{vld: pix_vld, adv: adv};

    // input register
    rrsd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .adv      (adv),
        .pix_vld  (pix_vld),
        .pix      (pix)
    );

    // run tracking and straightness test
    rrsd_run_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .pix         (pix),
        .res_vld     (res_vld),
        .res         (res)
    );

    // result register
    rrsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_vld  (res_vld),
        .res      (res),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/rrsd_in_stage.sv @@
// input register of the segment detector: takes slave-side transfers
// depends on rrsd_pkg
module rrsd_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrsd_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] depth
    input  logic                          s_tlast,  // row_end
    input  logic [rrsd_pkg::S_TUSER_W-1:0] s_tuser,  // [0] edge_bit, [1] frame_start
    input  logic                          adv,
    output logic                          pix_vld,
    output rrsd_pkg::pixel_t              pix
);
    import rrsd_pkg::*;

    logic   vld_reg;
    logic   vld_next;
    pixel_t pix_reg;
    pixel_t pix_next;

    // register frees when empty or when the core consumes it
    assign s_tready = !vld_reg || adv;

    always_comb begin
        vld_next = vld_reg;
        pix_next = pix_reg;
        if (s_tready) begin
            vld_next = s_tvalid;
            pix_next.edge_bit    = s_tuser[TUSER_EDGE_BIT];
            pix_next.depth       = s_tdata[DEPTH_IN_W-1:0];
            pix_next.row_end     = s_tlast;
            pix_next.frame_start = s_tuser[TUSER_FRAME_BIT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        pix_reg <= pix_next;
    end

    assign pix_vld = vld_reg;
    assign pix     = pix_reg;

endmodule

@@ rtl/rrsd_run_core.sv @@
// run tracking core: column/row/label counters, run state and straightness test
// depends on rrsd_pkg
module rrsd_run_core #(
    parameter int MAX_WIDTH  = rrsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rrsd_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = rrsd_pkg::DEF_DEPTH_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rrsd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  rrsd_pkg::stage_ctl_t        ctl,
    input  rrsd_pkg::pixel_t            pix,
    output logic                        res_vld,
    output rrsd_pkg::result_t           res
);
    import rrsd_pkg::*;

    localparam int DW   = DEPTH_BITS;
    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int LENW = $clog2(MAX_WIDTH + 1);
    localparam int ROWW = $clog2((MAX_HEIGHT > 1) ? MAX_HEIGHT : 2);
    localparam int CMPW = (DW + 2 > CFG_W) ? DW + 2 : CFG_W;

    logic [CFG_W-1:0]    thr_reg;
    logic                prev_edge_reg,  prev_edge_next;
    logic [DW-1:0]       prev_depth_reg, prev_depth_next;
    logic                in_run_reg,     in_run_next;
    logic [COLW-1:0]     run_start_reg,  run_start_next;
    logic [LENW-1:0]     run_len_reg,    run_len_next;
    logic signed [DW:0]  diff_min_reg,   diff_min_next;
    logic signed [DW:0]  diff_max_reg,   diff_max_next;
    logic [COLW-1:0]     col_reg,        col_next;
    logic [ROWW-1:0]     row_reg,        row_next;
    logic [LABEL_W-1:0]  label_reg,      label_next;

    logic                fire;
    logic                emit;
    logic [COLW-1:0]     col_cur;
    logic [ROWW-1:0]     row_cur;
    logic [LABEL_W-1:0]  label_cur;
    logic [LABEL_W-1:0]  label_inc;
    logic                in_run_cur;
    logic [31:0]         depth_wide;
    logic [DW-1:0]       depth_cur;
    logic signed [DW:0]  diff;
    logic signed [DW:0]  mn;
    logic signed [DW:0]  mx;
    logic [DW+1:0]       spread;
    logic                straight;
    logic [31:0]         row_wide;
    logic [31:0]         start_wide;
    logic [31:0]         len_wide;

    assign fire = ctl.vld && ctl.adv;

    // frame start clears counters before the pixel is handled
    assign col_cur    = pix.frame_start ? '0 : col_reg;
    assign row_cur    = pix.frame_start ? '0 : row_reg;
    assign label_cur  = pix.frame_start ? '0 : label_reg;
    assign in_run_cur = pix.frame_start ? 1'b0 : in_run_reg;
    assign label_inc  = (label_cur == LABEL_MAX) ? label_cur : label_cur + 1'b1;

    // depth limited to DEPTH_BITS, difference to the left neighbour
    assign depth_wide = 32'(pix.depth);
    assign depth_cur  = depth_wide[DW-1:0];
    assign diff = $signed({1'b0, depth_cur}) - $signed({1'b0, prev_depth_reg});

    // running min/max of the differences, first difference seeds both
    assign mn = (run_len_reg == LENW'(1)) ? diff :
                ((diff < diff_min_reg) ? diff : diff_min_reg);
    assign mx = (run_len_reg == LENW'(1)) ? diff :
                ((diff > diff_max_reg) ? diff : diff_max_reg);
    assign spread   = $unsigned({mx[DW], mx} - {mn[DW], mn});
    assign straight = CMPW'(spread) <= CMPW'(thr_reg);
    assign emit     = in_run_cur && pix.edge_bit && straight;

    // next state of the run tracker
    always_comb begin
        prev_edge_next  = prev_edge_reg;
        prev_depth_next = prev_depth_reg;
        in_run_next     = in_run_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        diff_min_next   = diff_min_reg;
        diff_max_next   = diff_max_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        label_next      = label_reg;
        if (fire) begin
            in_run_next = in_run_cur;
            label_next  = label_cur;
            if (in_run_cur) begin
                diff_min_next = mn;
                diff_max_next = mx;
                if (run_len_reg < LENW'(MAX_WIDTH)) begin
                    run_len_next = run_len_reg + 1'b1;
                end
                if (pix.edge_bit) begin
                    in_run_next = 1'b0;
                    if (straight) begin
                        label_next = label_inc;
                    end
                end
            end else if ((col_cur != '0) && prev_edge_reg && !pix.edge_bit) begin
                in_run_next    = 1'b1;
                run_start_next = col_cur;
                run_len_next   = LENW'(1);
                diff_min_next  = '0;
                diff_max_next  = '0;
            end
            prev_edge_next  = pix.edge_bit;
            prev_depth_next = depth_cur;
            // row end, flagged or forced by the width limit
            if (pix.row_end || (col_cur >= COLW'(MAX_WIDTH - 1))) begin
                in_run_next = 1'b0;
                col_next    = '0;
                row_next    = (row_cur < ROWW'(MAX_HEIGHT - 1)) ? row_cur + 1'b1 : row_cur;
            end else begin
                col_next = col_cur + 1'b1;
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= '0;
            prev_edge_reg  <= 1'b0;
            prev_depth_reg <= '0;
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            diff_min_reg   <= '0;
            diff_max_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            label_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            prev_edge_reg  <= prev_edge_next;
            prev_depth_reg <= prev_depth_next;
            in_run_reg     <= in_run_next;
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            diff_min_reg   <= diff_min_next;
            diff_max_reg   <= diff_max_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            label_reg      <= label_next;
        end
    end

    // result fields cut to the output widths
    assign row_wide   = 32'(row_cur);
    assign start_wide = 32'(run_start_reg);
    assign len_wide   = 32'(run_len_next);

    assign res_vld               = fire && emit;
    assign res.segment_row       = row_wide[ROW_OUT_W-1:0];
    assign res.segment_start_col = start_wide[COL_OUT_W-1:0];
    assign res.segment_length    = len_wide[LEN_OUT_W-1:0];
    assign res.segment_label     = label_inc;

`ifndef SYNTHESIS
    // a reported run always spans at least the opening pixel and the closing edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |-> run_len_next >= LENW'(2))
        else $error("segment reported with fewer than two pixels");

    // an open run has at least its first pixel counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_run_reg |-> run_len_reg != '0)
        else $error("open run with zero length");

    // column counter never passes the last column
    assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COLW'(MAX_WIDTH - 1))
        else $error("column counter beyond row width");

    // saturated label holds until a new frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (label_reg == LABEL_MAX) && !(fire && pix.frame_start) |=> label_reg == LABEL_MAX)
        else $error("saturated label count moved");
`endif

endmodule

@@ rtl/rrsd_out_stage.sv @@
// result register: holds one segment report for the master-side transfer
// depends on rrsd_pkg
module rrsd_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           res_vld,
    input  rrsd_pkg::result_t              res,
    output logic                           adv,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] segment_row, [21:11] segment_start_col, [33:22] segment_length,
    // [49:34] segment_label, [55:50] zero
    output logic [rrsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrsd_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;
    result_t res_next;

    // pipeline moves when the register is empty or being taken
    assign adv = !vld_reg || m_tready;

    always_comb begin
        vld_next = vld_reg;
        res_next = res_reg;
        if (adv) begin
            vld_next = res_vld;
            res_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, res_reg};

endmodule
